// File: hw/rtl/mandelbrot_cell_escape_time_core_defines.svh
// Assertion macros shared by the escape-time core and its lanes.
`ifndef MANDELBROT_CELL_ESCAPE_TIME_CORE_DEFINES_SVH
`define MANDELBROT_CELL_ESCAPE_TIME_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define MCET_ASSERT_IMPLIES(label, ck, rn, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define MCET_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/mcet_pkg.sv
// Types, constants and fixed-point helpers of the escape-time core.
package mcet_pkg;

  localparam int FRAC_BITS  = 56;
  localparam int ITER_WIDTH = 16;
  localparam int COLOR_W    = 9;
  localparam int CMP_W      = (FRAC_BITS + 7 > 65) ? FRAC_BITS + 7 : 65;
  localparam int MUL_STEPS  = 4;
  localparam int STEP_W     = $clog2(MUL_STEPS + 1);
  localparam int CFG_IDX_W  = 3;

  localparam logic [STEP_W-1:0]     STEP_LAST    = STEP_W'(MUL_STEPS);
  localparam logic [ITER_WIDTH-1:0] MAX_ITER_RST = ITER_WIDTH'(215);
  localparam logic [6:0]            BAILOUT_RST  = 7'd4;
  localparam logic [7:0]            BASE_RST     = 8'd16;
  localparam logic [8:0]            COUNT_RST    = 9'd216;
  localparam logic signed [63:0]    S64_MAX      = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0]    S64_MIN      = {1'b1, 63'd0};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_ITER    = 3'd0,
    REG_BAILOUT     = 3'd1,
    REG_HALF_RE     = 3'd2,
    REG_HALF_IM     = 3'd3,
    REG_COLOR_BASE  = 3'd4,
    REG_COLOR_COUNT = 3'd5
  } cfg_reg_t;

  typedef enum logic [2:0] {
    L_IDLE,
    L_MAG,
    L_MUL,
    L_FIX,
    L_UPD,
    L_ADD,
    L_DONE
  } lane_state_t;

  typedef struct packed {
    logic signed [63:0] point_re;
    logic signed [63:0] point_im;
  } in_word_t;

  typedef struct packed {
    logic [COLOR_W-1:0] upper_color;
    logic [COLOR_W-1:0] lower_color;
    logic               glyph;
  } out_word_t;

  typedef struct packed {
    logic [ITER_WIDTH-1:0] max_iter;
    logic [6:0]            bailout_limit;
    logic [7:0]            color_base;
    logic [8:0]            color_count;
  } lane_cfg_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [COLOR_W-1:0] color;
  } lane_stat_t;

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] x,
                                                 input logic signed [63:0] y);
    logic [63:0]        r;
    logic signed [63:0] res;
    r   = x + y;
    res = r;
    if ((x[63] == y[63]) && (r[63] != x[63])) begin
      res = x[63] ? S64_MIN : S64_MAX;
    end
    return res;
  endfunction

  function automatic logic [63:0] mag64(input logic signed [63:0] x);
    return x[63] ? (~x + 64'd1) : x;
  endfunction

  // Magnitude product to signed fixed point, floor rounding and saturation.
  function automatic logic signed [63:0] mul_fix(input logic [127:0] p,
                                                 input logic neg,
                                                 input logic dbl);
    logic [127:0]       q;
    logic               rem;
    logic signed [63:0] res;
    q   = dbl ? (p >> (FRAC_BITS - 1)) : (p >> FRAC_BITS);
    rem = dbl ? (|p[FRAC_BITS-2:0]) : (|p[FRAC_BITS-1:0]);
    if (!neg) begin
      res = (|q[127:63]) ? S64_MAX : q[63:0];
    end else if ((|q[127:64]) || (q[63] && ((|q[62:0]) || rem))) begin
      res = S64_MIN;
    end else begin
      res = rem ? ~q[63:0] : (~q[63:0] + 64'd1);
    end
    return res;
  endfunction

endpackage

// File: hw/rtl/mcet_lane.sv
// One iteration lane: escape-time count and colour of a single sample point.
`include "mandelbrot_cell_escape_time_core_defines.svh"

module mcet_lane import mcet_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               ack,
  input  logic signed [63:0] c_re,
  input  logic signed [63:0] c_im,
  input  lane_cfg_t          cfg,
  output lane_stat_t         stat
);

  lane_state_t state_r, state_nxt;
  logic [STEP_W-1:0] step_r;

  logic signed [63:0] cr_r, ci_r, a_r, b_r;
  logic [63:0]        am_r, bm_r;
  logic               neg_ab_r;
  logic [63:0]        pp_aa_r, pp_bb_r, pp_ab_r;
  logic [1:0]         pp_sh_r;
  logic [127:0]       acc_aa_r, acc_bb_r, acc_ab_r;
  logic signed [63:0] a2_r, b2_r, ab2_r, diff_r;
  logic [ITER_WIDTH-1:0] cnt_r, cnt_p1;
  logic [8:0]         mod_r, mod_nxt;
  logic [9:0]         mod_p1;
  logic [COLOR_W-1:0] color_r;

  logic        x_hi, y_hi;
  logic [31:0] xa, ya, xb, yb;
  logic [64:0] sum_sq;
  logic        escape, last_iter;

  assign x_hi = step_r[1];
  assign y_hi = step_r[0];
  assign xa = x_hi ? am_r[63:32] : am_r[31:0];
  assign ya = y_hi ? am_r[63:32] : am_r[31:0];
  assign xb = x_hi ? bm_r[63:32] : bm_r[31:0];
  assign yb = y_hi ? bm_r[63:32] : bm_r[31:0];

  assign sum_sq    = {1'b0, a2_r} + {1'b0, b2_r};
  assign escape    = CMP_W'(sum_sq) > (CMP_W'(cfg.bailout_limit) << FRAC_BITS);
  assign cnt_p1    = cnt_r + ITER_WIDTH'(1);
  assign last_iter = (cnt_p1 == cfg.max_iter);
  assign mod_p1    = {1'b0, mod_r} + 10'd1;
  assign mod_nxt   = (mod_p1 == {1'b0, cfg.color_count}) ? 9'd0 : mod_p1[8:0];

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      L_IDLE: begin
        if (start) begin
          state_nxt = (cfg.max_iter == '0) ? L_DONE : L_MAG;
        end
      end
      L_MAG: state_nxt = L_MUL;
      L_MUL: begin
        if (step_r == STEP_LAST) begin
          state_nxt = L_FIX;
        end
      end
      L_FIX: state_nxt = L_UPD;
      L_UPD: state_nxt = (escape || last_iter) ? L_DONE : L_ADD;
      L_ADD: state_nxt = L_MAG;
      L_DONE: begin
        if (ack) begin
          state_nxt = L_IDLE;
        end
      end
      default: state_nxt = L_IDLE;
    endcase
  end

  always_comb begin
    stat.busy  = (state_r != L_IDLE);
    stat.done  = (state_r == L_DONE);
    stat.color = color_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= L_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == L_MAG) begin
        step_r <= '0;
      end else if (state_r == L_MUL) begin
        step_r <= step_r + STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      L_IDLE: begin
        if (start) begin
          cr_r    <= c_re;
          ci_r    <= c_im;
          a_r     <= '0;
          b_r     <= '0;
          cnt_r   <= '0;
          mod_r   <= '0;
          color_r <= '0;
        end
      end
      L_MAG: begin
        am_r     <= mag64(a_r);
        bm_r     <= mag64(b_r);
        neg_ab_r <= a_r[63] ^ b_r[63];
        acc_aa_r <= '0;
        acc_bb_r <= '0;
        acc_ab_r <= '0;
      end
      L_MUL: begin
        if (step_r < STEP_LAST) begin
          pp_aa_r <= 64'(xa) * 64'(ya);
          pp_bb_r <= 64'(xb) * 64'(yb);
          pp_ab_r <= 64'(xa) * 64'(yb);
          pp_sh_r <= {x_hi & y_hi, x_hi ^ y_hi};
        end
        if (step_r != '0) begin
          acc_aa_r <= acc_aa_r + ({64'd0, pp_aa_r} << {pp_sh_r, 5'd0});
          acc_bb_r <= acc_bb_r + ({64'd0, pp_bb_r} << {pp_sh_r, 5'd0});
          acc_ab_r <= acc_ab_r + ({64'd0, pp_ab_r} << {pp_sh_r, 5'd0});
        end
      end
      L_FIX: begin
        a2_r  <= mul_fix(acc_aa_r, 1'b0, 1'b0);
        b2_r  <= mul_fix(acc_bb_r, 1'b0, 1'b0);
        ab2_r <= mul_fix(acc_ab_r, neg_ab_r, 1'b1);
      end
      L_UPD: begin
        diff_r  <= a2_r - b2_r;
        color_r <= escape ? (COLOR_W'(cfg.color_base) + mod_r) : '0;
        if (!escape) begin
          cnt_r <= cnt_p1;
          mod_r <= mod_nxt;
        end
      end
      L_ADD: begin
        a_r <= sat_add(diff_r, cr_r);
        b_r <= sat_add(ab2_r, ci_r);
      end
      default: ;
    endcase
  end

  `MCET_ASSERT_NEXT(a_done_hold, clk, rst_n, (state_r == L_DONE && !ack),
    (state_r == L_DONE && $stable(color_r)), "lane dropped a finished colour")
  `MCET_ASSERT_IMPLIES(a_step_range, clk, rst_n, (state_r == L_MUL),
    (step_r <= STEP_LAST), "partial product step out of range")
  `MCET_ASSERT_NEXT(a_upd_exit, clk, rst_n, (state_r == L_UPD),
    (state_r == L_ADD || state_r == L_DONE), "bad exit from the update step")

endmodule

// File: hw/rtl/mcet_merge.sv
// Merging stage: pairs the two lane colours, picks the glyph and holds the result word.
module mcet_merge import mcet_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  lane_stat_t up,
  input  lane_stat_t lo,
  output logic       ack,
  output logic       out_valid,
  input  logic       out_ready,
  output out_word_t  out_data
);

  logic      out_valid_r;
  out_word_t out_data_r;

  assign ack       = up.done && lo.done && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ack) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ack) begin
      out_data_r.upper_color <= up.color;
      out_data_r.lower_color <= lo.color;
      out_data_r.glyph       <= (up.color != lo.color);
    end
  end

endmodule

// File: hw/rtl/mandelbrot_cell_escape_time_core.sv
// Top level of the escape-time core: registers, two sample lanes and the merging stage.
//
// Channel  Direction  Handshake                  Word
// in       input      in_valid / in_ready        in_data   (point_re, point_im)
// out      output     out_valid / out_ready      out_data  (upper_color, lower_color, glyph)
// cfg      input      cfg_valid / cfg_ready      cfg_index, cfg_data
//
// Each lane runs each iteration as a sequence of steps: magnitudes, four partial products of its
// 32 by 32 multipliers plus one accumulate, rounding, escape test and the coordinate update.
// The result word is registered once both lanes are done and the output register is free;
// a max_iter of zero sends both lanes straight to done without any escape test.
// A new word is taken once both lanes are free, even while the last result still waits.
// Reset is synchronous; cfg_ready is always high.
`include "mandelbrot_cell_escape_time_core_defines.svh"

module mandelbrot_cell_escape_time_core import mcet_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_word_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_word_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_data
);

  logic [ITER_WIDTH-1:0] max_iter_r;
  logic [6:0]            bailout_r;
  logic signed [63:0]    half_re_r, half_im_r;
  logic [7:0]            color_base_r;
  logic [8:0]            color_count_r;

  lane_cfg_t          lane_cfg;
  lane_stat_t         up_stat, lo_stat;
  logic               start, ack;
  logic signed [63:0] lo_re, lo_im;

  assign cfg_ready = 1'b1;
  assign in_ready  = !up_stat.busy && !lo_stat.busy;
  assign start     = in_valid && in_ready;
  assign lo_re     = sat_add(in_data.point_re, half_re_r);
  assign lo_im     = sat_add(in_data.point_im, half_im_r);

  assign lane_cfg = '{max_iter: max_iter_r, bailout_limit: bailout_r,
                      color_base: color_base_r, color_count: color_count_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_iter_r    <= MAX_ITER_RST;
      bailout_r     <= BAILOUT_RST;
      half_re_r     <= '0;
      half_im_r     <= '0;
      color_base_r  <= BASE_RST;
      color_count_r <= COUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MAX_ITER:    max_iter_r    <= ITER_WIDTH'(cfg_data[15:0]);
        REG_BAILOUT:     bailout_r     <= cfg_data[6:0];
        REG_HALF_RE:     half_re_r     <= cfg_data;
        REG_HALF_IM:     half_im_r     <= cfg_data;
        REG_COLOR_BASE:  color_base_r  <= cfg_data[7:0];
        REG_COLOR_COUNT: color_count_r <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  mcet_lane u_lane_up (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .ack   (ack),
    .c_re  (in_data.point_re),
    .c_im  (in_data.point_im),
    .cfg   (lane_cfg),
    .stat  (up_stat)
  );

  mcet_lane u_lane_lo (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .ack   (ack),
    .c_re  (lo_re),
    .c_im  (lo_im),
    .cfg   (lane_cfg),
    .stat  (lo_stat)
  );

  mcet_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .up        (up_stat),
    .lo        (lo_stat),
    .ack       (ack),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  `MCET_ASSERT_NEXT(a_start_busy, clk, rst_n, (in_valid && in_ready),
    (up_stat.busy && lo_stat.busy), "lanes did not start on an accepted word")
  `MCET_ASSERT_NEXT(a_ack_clears, clk, rst_n, ack,
    (!up_stat.done && !lo_stat.done), "lanes still done after their result was taken")
  `MCET_ASSERT_IMPLIES(a_out_from_ack, clk, rst_n, $rose(out_valid),
    $past(ack), "result word appeared without both lanes finishing")

endmodule
